>>> rtl/spq_pkg.sv
// package: types, constants and helpers for the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // store size and derived widths
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = ADDR_W + 1;

    // field widths
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + STAT_W + OCC_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - (DATA_W + STAT_W + OCC_W);

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_DEL_RD,
        ST_DEL_TAKE,
        ST_RESP
    } t_state;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } t_entry;

    // fold a head-relative sum back into the circular store
    function automatic logic [ADDR_W-1:0] f_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] folded;
        begin
            folded = (sum >= SUM_W'(CAPACITY)) ? sum - SUM_W'(CAPACITY) : sum;
            f_wrap = folded[ADDR_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// top level: bounded priority queue kept sorted in a circular store
// path from input transfer to result valid: an empty delete or a full insert goes straight
//   to the response step, a delete reads the head and then takes it, and an insert scans
//   from the tail toward the head, moving each larger entry one place back until it lands
// throughput: one item at a time, ready again the cycle after the result loads; the
//   insertion scan (a read, then a compare and a move, per entry moved) sets the worst case
// reset: synchronous active-low clears count, head, sequencer and output valid; the
//   store itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    // [31:0] item_value, [63:32] priority
    input  wire [spq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] action
    input  wire                          i_s_tuser,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    // [31:0] removed_value, [33:32] status, [38:34] occupancy, [39] zero
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import spq_pkg::*;

    // sequencer and control registers
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_pos;
    logic                r_action;
    t_entry              r_item;
    logic [DATA_W-1:0]   r_res_value;
    logic [STAT_W-1:0]   r_res_status;
    logic                r_m_valid;
    logic [DATA_W-1:0]   r_m_value;
    logic [STAT_W-1:0]   r_m_status;
    logic [OCC_W-1:0]    r_m_occ;

    // store and its registered read port
    t_entry              r_mem [CAPACITY];
    t_entry              r_rd_data;

    // sequencer strobes
    logic                s_accept;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_entry              mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                count_inc;
    logic                count_dec;
    logic                pos_dec;
    logic                take_head;
    logic                load_out;
    logic                prio_greater;
    logic [CNT_W-1:0]    pos_m1;

    assign s_accept     = i_s_tvalid && o_s_tready;
    assign prio_greater = r_rd_data.prio > r_item.prio;
    assign pos_m1       = r_pos - CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == ACT_INSERT) begin
                        n_state = (r_count >= CNT_W'(CAPACITY)) ? ST_RESP : ST_INS_RD;
                    end else begin
                        n_state = (r_count == '0) ? ST_RESP : ST_DEL_RD;
                    end
                end
            end
            ST_INS_RD: begin
                n_state = (r_pos == '0) ? ST_RESP : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                n_state = prio_greater ? ST_INS_RD : ST_RESP;
            end
            ST_DEL_RD: begin
                n_state = ST_DEL_TAKE;
            end
            ST_DEL_TAKE: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = f_wrap(SUM_W'(r_head) + SUM_W'(r_pos));
        mem_wdata  = r_item;
        mem_raddr  = f_wrap(SUM_W'(r_head) + SUM_W'(pos_m1));
        count_inc  = 1'b0;
        count_dec  = 1'b0;
        pos_dec    = 1'b0;
        take_head  = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_INS_RD: begin
                // hole reached the head: drop the new entry in
                if (r_pos == '0) begin
                    mem_we    = 1'b1;
                    count_inc = 1'b1;
                end
            end
            ST_INS_CMP: begin
                if (prio_greater) begin
                    // move the larger entry one place back
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    pos_dec   = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    count_inc = 1'b1;
                end
            end
            ST_DEL_RD: begin
                mem_raddr = r_head;
            end
            ST_DEL_TAKE: begin
                take_head = 1'b1;
                count_dec = 1'b1;
            end
            ST_RESP: begin
                load_out = !r_m_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (count_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (count_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (take_head) begin
                r_head <= (r_head == ADDR_W'(CAPACITY - 1)) ? '0 : r_head + ADDR_W'(1);
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item, scan position and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action      <= i_s_tuser;
            r_item.value  <= i_s_tdata[DATA_W-1:0];
            r_item.prio   <= i_s_tdata[2*DATA_W-1:DATA_W];
            r_pos         <= r_count;
            r_res_value   <= '0;
            if (i_s_tuser == ACT_INSERT) begin
                r_res_status <= (r_count >= CNT_W'(CAPACITY)) ? STAT_FULL : STAT_OK;
            end else begin
                r_res_status <= (r_count == '0) ? STAT_UNDERFLOW : STAT_OK;
            end
        end
        if (pos_dec) begin
            r_pos <= pos_m1;
        end
        if (take_head) begin
            r_res_value <= r_rd_data.value;
        end
        if (load_out) begin
            r_m_value  <= r_res_value;
            r_m_status <= r_res_status;
            r_m_occ    <= OCC_W'(r_count);
        end
    end

    // result port
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_m_occ, r_m_status, r_m_value};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_RD || r_state == ST_INS_CMP) |-> r_pos <= r_count)
        else $error("insert scan position beyond stored entries");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_RD || r_state == ST_INS_CMP) |->
            (r_count < CNT_W'(CAPACITY) && r_action == ACT_INSERT))
        else $error("insert scan on a full store");

    a_del_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEL_RD || r_state == ST_DEL_TAKE) |-> r_count != '0)
        else $error("delete from an empty store");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_RESP))
        else $error("result presented outside the response step");

endmodule

`default_nettype wire
